// File: rtl/bb3c_pkg.sv
// Shared types, constants and a helper function for the 3x3 clipped box blur.
// Used by box_blur_3x3_clipped and the testbench; no dependencies of its own.
package bb3c_pkg;

	localparam int MAX_DIM_DEF = 512;
	localparam int FS_W        = 10;
	localparam int CH_W        = 16;
	localparam int POS_W       = 9;
	localparam int PIX_W       = 3 * CH_W;
	localparam int SUM_W       = 20;
	localparam int NUM_W       = 4;
	localparam int RECIP_SH    = 24;
	localparam int RECIP_W     = RECIP_SH + 1;
	localparam int PROD_W      = SUM_W + RECIP_W;

	typedef struct packed {
		logic [CH_W-1:0] in_red;
		logic [CH_W-1:0] in_green;
		logic [CH_W-1:0] in_blue;
	} in_word_t;

	typedef struct packed {
		logic [CH_W-1:0]  out_red;
		logic [CH_W-1:0]  out_green;
		logic [CH_W-1:0]  out_blue;
		logic [POS_W-1:0] out_row;
		logic [POS_W-1:0] out_col;
		logic             run_end;
		logic             frame_end;
	} out_word_t;

	// floor(2^24 / d) for the divisors a clipped window can have
	function automatic logic [RECIP_W-1:0] recip(input logic [NUM_W-1:0] d);
		logic [RECIP_W-1:0] m;
		case (d)
			4'd1:    m = RECIP_W'(25'd16777216);
			4'd2:    m = RECIP_W'(25'd8388608);
			4'd3:    m = RECIP_W'(25'd5592405);
			4'd4:    m = RECIP_W'(25'd4194304);
			4'd6:    m = RECIP_W'(25'd2796202);
			4'd9:    m = RECIP_W'(25'd1864135);
			default: m = RECIP_W'(25'd16777216);
		endcase
		return m;
	endfunction

endpackage

// File: rtl/box_blur_3x3_clipped.sv
// Top level of the 3x3 clipped box blur; uses bb3c_pkg and two bb3c_ram line stores.
// Flow: a new pixel is taken only in the idle state, after the line store read and the
//   sum, reciprocal multiply and fix-up of each of its results (up to 4), which can stall on out_ready.
// Reset: frame size MAX_DIM, position row 0 column 0; line stores need no clearing.
module box_blur_3x3_clipped
	import bb3c_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [FS_W-1:0] cfg_data,
	input  logic            in_valid,
	output logic            in_ready,
	input  in_word_t        in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output out_word_t       out_data
);

	localparam int AW = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_FIX  = 3'd4;

	logic [2:0]      state_q;
	logic [FS_W-1:0] fs_q;
	logic [AW-1:0]   row_q, col_q;
	logic [AW-1:0]   last, r, c;
	logic [AW-1:0]   r_q, c_q, last_q;
	logic [PIX_W-1:0] cur_q;
	logic [PIX_W-1:0] rd_a, rd_b;
	logic [PIX_W-1:0] win_q [6];
	logic [PIX_W-1:0] grid_q [9];
	logic            ri_q, ci_q;
	logic            has_rp, has_rc, has_cp, has_cc;
	logic [2:0]      rmask, cmask;
	logic [SUM_W-1:0] sum_q [3];
	logic [NUM_W-1:0] num_q;
	logic [PROD_W-1:0] prod_q [3];
	logic [AW-1:0]   orow, ocol;
	logic            more;
	logic            next_ri, next_ci;
	logic            out_free;
	logic            acc;

	assign acc       = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || out_ready;

	always_comb begin
		if (fs_q == '0) begin
			last = '0;
		end else if (32'(fs_q) > MAX_DIM) begin
			last = AW'(MAX_DIM - 1);
		end else begin
			last = AW'(fs_q - FS_W'(1));
		end
		r = (row_q > last) ? last : row_q;
		c = (col_q > last) ? last : col_q;
	end

	bb3c_ram #(.WIDTH(PIX_W), .DEPTH(MAX_DIM)) u_line_a (
		.clk   (clk),
		.we    (state_q == ST_RD),
		.waddr (c_q),
		.wdata (cur_q),
		.re    (acc),
		.raddr (c),
		.rdata (rd_a)
	);

	bb3c_ram #(.WIDTH(PIX_W), .DEPTH(MAX_DIM)) u_line_b (
		.clk   (clk),
		.we    (state_q == ST_RD),
		.waddr (c_q),
		.wdata (rd_a),
		.re    (acc),
		.raddr (c),
		.rdata (rd_b)
	);

	// result enumeration: rows r-1 then r, columns c-1 then c
	always_comb begin
		has_rp  = (r_q != '0);
		has_rc  = (r_q == last_q);
		has_cp  = (c_q != '0);
		has_cc  = (c_q == last_q);
		more    = 1'b0;
		next_ri = ri_q;
		next_ci = ci_q;
		if (!ci_q && has_cc) begin
			more    = 1'b1;
			next_ci = 1'b1;
		end else if (!ri_q && has_rc) begin
			more    = 1'b1;
			next_ri = 1'b1;
			next_ci = !has_cp;
		end
		orow = ri_q ? r_q : r_q - AW'(1);
		ocol = ci_q ? c_q : c_q - AW'(1);
		// bit k: grid row r-2+k (rmask) or grid column c-2+k (cmask)
		if (!ri_q) begin
			rmask = {1'b1, 1'b1, r_q > AW'(1)};
		end else begin
			rmask = {1'b1, has_rp, 1'b0};
		end
		if (!ci_q) begin
			cmask = {1'b1, 1'b1, c_q > AW'(1)};
		end else begin
			cmask = {1'b1, has_cp, 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		logic [SUM_W-1:0] s [3];
		logic [SUM_W-1:0] q;
		logic [SUM_W+NUM_W-1:0] qd;
		if (acc) begin
			cur_q <= {in_data.in_blue, in_data.in_green, in_data.in_red};
			r_q    <= r;
			c_q    <= c;
			last_q <= last;
		end
		if (state_q == ST_RD) begin
			grid_q[0] <= win_q[3];
			grid_q[1] <= win_q[4];
			grid_q[2] <= win_q[5];
			grid_q[3] <= win_q[0];
			grid_q[4] <= win_q[1];
			grid_q[5] <= win_q[2];
			grid_q[6] <= rd_b;
			grid_q[7] <= rd_a;
			grid_q[8] <= cur_q;
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= rd_b;
			win_q[1] <= rd_a;
			win_q[2] <= cur_q;
		end
		if (state_q == ST_SUM) begin
			for (int k = 0; k < 3; k++) begin
				s[k] = '0;
				for (int x = 0; x < 3; x++) begin
					for (int y = 0; y < 3; y++) begin
						if (cmask[x] && rmask[y]) begin
							s[k] = s[k] + SUM_W'(grid_q[x*3+y][k*CH_W +: CH_W]);
						end
					end
				end
				sum_q[k] <= s[k];
			end
			num_q <= NUM_W'($countones(rmask)) * NUM_W'($countones(cmask));
		end
		if (state_q == ST_MUL) begin
			for (int k = 0; k < 3; k++) begin
				prod_q[k] <= PROD_W'(sum_q[k]) * PROD_W'(recip(num_q));
			end
		end
		if (state_q == ST_FIX && out_free) begin
			for (int k = 0; k < 3; k++) begin
				q  = SUM_W'(prod_q[k] >> RECIP_SH);
				qd = (SUM_W+NUM_W)'(q) * (SUM_W+NUM_W)'(num_q);
				if ((SUM_W+NUM_W)'(sum_q[k]) - qd >= (SUM_W+NUM_W)'(num_q)) begin
					q = q + SUM_W'(1);
				end
				s[k] = q;
			end
			out_data.out_red   <= s[0][CH_W-1:0];
			out_data.out_green <= s[1][CH_W-1:0];
			out_data.out_blue  <= s[2][CH_W-1:0];
			out_data.out_row   <= POS_W'(orow);
			out_data.out_col   <= POS_W'(ocol);
			out_data.run_end   <= !more;
			out_data.frame_end <= (orow == last_q) && (ocol == last_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fs_q      <= FS_W'(MAX_DIM);
			row_q     <= '0;
			col_q     <= '0;
			ri_q      <= 1'b0;
			ci_q      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (cfg_valid) begin
				fs_q  <= cfg_data;
				row_q <= '0;
				col_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						state_q <= ST_RD;
						if (c == last) begin
							col_q <= '0;
							row_q <= (r == last) ? '0 : r + AW'(1);
						end else begin
							col_q <= c + AW'(1);
							row_q <= r;
						end
					end
				end
				ST_RD: begin
					ri_q <= !has_rp;
					ci_q <= !has_cp;
					if ((has_rp || has_rc) && (has_cp || has_cc)) begin
						state_q <= ST_SUM;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SUM: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					if (out_free) begin
						out_valid <= 1'b1;
						ri_q      <= next_ri;
						ci_q      <= next_ci;
						state_q   <= more ? ST_SUM : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/bb3c_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bb3c_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 512
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: dv/tb.sv
// Self-checking testbench for box_blur_3x3_clipped: directed table then random frames.
// Depends on bb3c_pkg and the RTL top; each expected word is predicted or typed in.
module tb;
	import bb3c_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic            clk = 0;
	logic            arst_n = 0;
	logic            cfg_valid = 0;
	logic            cfg_ready;
	logic [FS_W-1:0] cfg_data = '0;
	logic            in_valid = 0;
	logic            in_ready;
	in_word_t        in_data = '0;
	logic            out_valid;
	logic            out_ready = 0;
	out_word_t       out_data;

	box_blur_3x3_clipped u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #5 clk = ~clk;

	initial begin
		#2ms;
		$display("box_blur_3x3_clipped regression: fail");
		$finish;
	end

	// predictor state
	logic [PIX_W-1:0] prev_row [MAX_DIM_DEF];
	logic [PIX_W-1:0] prev_row2 [MAX_DIM_DEF];
	logic [PIX_W-1:0] win [6];
	int unsigned      blur_row, blur_col;
	logic [FS_W-1:0]  blur_size = FS_W'(MAX_DIM_DEF);
	out_word_t        blur_q [$];

	int  errors = 0;
	int  words_in = 0, words_out = 0, size_writes = 0;
	bit  quiet = 0;
	int  stall = 0;

	function automatic logic [CH_W-1:0] chan(logic [PIX_W-1:0] p, int k);
		return p[CH_W*k +: CH_W];
	endfunction

	task automatic blur_predict(input in_word_t px, output out_word_t res [$]);
		int n, last, r, c, nr, nc, r0, r1, c0, c1, yi, xi, num;
		int orows [2];
		int ocols [2];
		int unsigned sum [3];
		logic [PIX_W-1:0] g [3][3];
		logic [PIX_W-1:0] cur, a, b;
		out_word_t w;
		res = {};
		n = blur_size;
		if (n < 1) n = 1;
		if (n > MAX_DIM_DEF) n = MAX_DIM_DEF;
		last = n - 1;
		r = (blur_row > last) ? last : blur_row;
		c = (blur_col > last) ? last : blur_col;
		cur = {px.in_blue, px.in_green, px.in_red};
		a = prev_row[c];
		b = prev_row2[c];
		g[2][0] = b; g[2][1] = a; g[2][2] = cur;
		for (int i = 0; i < 3; i++) begin
			g[1][i] = win[i];
			g[0][i] = win[3+i];
		end
		nr = 0; nc = 0;
		if (r >= 1) orows[nr++] = r - 1;
		if (r == last) orows[nr++] = r;
		if (c >= 1) ocols[nc++] = c - 1;
		if (c == last) ocols[nc++] = c;
		for (int i = 0; i < nr; i++) begin
			for (int j = 0; j < nc; j++) begin
				r0 = (orows[i] > 0) ? orows[i] - 1 : 0;
				r1 = (orows[i] + 1 > last) ? last : orows[i] + 1;
				c0 = (ocols[j] > 0) ? ocols[j] - 1 : 0;
				c1 = (ocols[j] + 1 > last) ? last : ocols[j] + 1;
				sum = '{0, 0, 0};
				num = 0;
				for (int y = r0; y <= r1; y++) begin
					for (int x = c0; x <= c1; x++) begin
						yi = y + 2 - r;
						xi = x + 2 - c;
						if (yi >= 0 && yi <= 2 && xi >= 0 && xi <= 2) begin
							for (int k = 0; k < 3; k++) sum[k] += chan(g[xi][yi], k);
							num++;
						end
					end
				end
				if (num == 0) num = 1;
				w.out_red   = CH_W'(sum[0] / num);
				w.out_green = CH_W'(sum[1] / num);
				w.out_blue  = CH_W'(sum[2] / num);
				w.out_row   = POS_W'(orows[i]);
				w.out_col   = POS_W'(ocols[j]);
				w.run_end   = 0;
				w.frame_end = (orows[i] == last && ocols[j] == last);
				res.push_back(w);
			end
		end
		if (res.size() > 0) res[res.size()-1].run_end = 1;
		prev_row2[c] = a;
		prev_row[c] = cur;
		for (int i = 0; i < 3; i++) win[3+i] = win[i];
		win[0] = b; win[1] = a; win[2] = cur;
		if (c == last) begin
			blur_col = 0;
			blur_row = (r == last) ? 0 : r + 1;
		end else begin
			blur_col = c + 1;
			blur_row = r;
		end
	endtask

	task automatic set_size(input logic [FS_W-1:0] v);
		wait (blur_q.size() == 0);
		repeat (12) @(posedge clk);
		cfg_valid <= 1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		blur_size = v;
		blur_row = 0;
		blur_col = 0;
		size_writes++;
	endtask

	task automatic send_word(input in_word_t px, input bit typed, input out_word_t typed_exp);
		int gap;
		out_word_t res [$];
		gap = quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		in_data  <= px;
		do @(posedge clk); while (!in_ready);
		words_in++;
		blur_predict(px, res);
		if (typed) res = {typed_exp};
		foreach (res[i]) blur_q.push_back(res[i]);
	endtask

	task automatic check_word(input out_word_t e, input out_word_t g);
		if (g.out_red !== e.out_red) begin
			$error("out_red exp %h got %h", e.out_red, g.out_red); errors++;
		end
		if (g.out_green !== e.out_green) begin
			$error("out_green exp %h got %h", e.out_green, g.out_green); errors++;
		end
		if (g.out_blue !== e.out_blue) begin
			$error("out_blue exp %h got %h", e.out_blue, g.out_blue); errors++;
		end
		if (g.out_row !== e.out_row) begin
			$error("out_row exp %0d got %0d", e.out_row, g.out_row); errors++;
		end
		if (g.out_col !== e.out_col) begin
			$error("out_col exp %0d got %0d", e.out_col, g.out_col); errors++;
		end
		if (g.run_end !== e.run_end) begin
			$error("run_end exp %b got %b", e.run_end, g.run_end); errors++;
		end
		if (g.frame_end !== e.frame_end) begin
			$error("frame_end exp %b got %b", e.frame_end, g.frame_end); errors++;
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			words_out++;
			if (blur_q.size() == 0) begin
				$error("unexpected word row %0d col %0d", out_data.out_row, out_data.out_col);
				errors++;
			end else begin
				check_word(blur_q.pop_front(), out_data);
			end
			stall = quiet ? 0 : $urandom_range(0, 18);
		end else if (stall > 0) begin
			stall--;
		end
		out_ready <= (stall == 0);
	end

	typedef struct {
		bit              cfg;
		logic [FS_W-1:0] size;
		in_word_t        px;
		bit              typed;
		out_word_t       exp;
	} stim_row_t;

	function automatic logic [CH_W-1:0] rand_chan();
		int s;
		s = $urandom_range(0, 7);
		if (s == 0) return '0;
		if (s == 1) return '1;
		return CH_W'($urandom);
	endfunction

	stim_row_t dir_tab [$];
	int        phase_size [6] = '{4, 512, 7, 3, 1, 5};
	int        phase_len  [6] = '{16, 8, 25, 16, 6, 19};

	initial begin
		in_word_t p;
		out_word_t none;
		none = '0;
		// frame of one pixel: the word comes back unchanged
		dir_tab.push_back('{1, 1, '{16'h0000, 16'h0000, 16'h0000}, 1,
			'{16'h0000, 16'h0000, 16'h0000, 0, 0, 1, 1}});
		dir_tab.push_back('{0, 0, '{16'hffff, 16'hffff, 16'hffff}, 1,
			'{16'hffff, 16'hffff, 16'hffff, 0, 0, 1, 1}});
		dir_tab.push_back('{0, 0, '{16'hffff, 16'h0000, 16'h1234}, 1,
			'{16'hffff, 16'h0000, 16'h1234, 0, 0, 1, 1}});
		// size 0 acts as 1
		dir_tab.push_back('{1, 0, '{16'h0001, 16'h0002, 16'h0003}, 1,
			'{16'h0001, 16'h0002, 16'h0003, 0, 0, 1, 1}});
		// oversize acts as the maximum: no word on the first row
		dir_tab.push_back('{1, 10'h3ff, '{16'hffff, 16'h0000, 16'hffff}, 0, none});
		dir_tab.push_back('{0, 0, '{16'h0000, 16'hffff, 16'h0000}, 0, none});
		// 2x2: four words on the last pixel
		dir_tab.push_back('{1, 2, '{16'hffff, 16'hffff, 16'hffff}, 0, none});
		dir_tab.push_back('{0, 0, '{16'hffff, 16'hffff, 16'hffff}, 0, none});
		dir_tab.push_back('{0, 0, '{16'h0000, 16'hfffe, 16'h0001}, 0, none});
		dir_tab.push_back('{0, 0, '{16'hffff, 16'h0000, 16'hffff}, 0, none});
		for (int i = 0; i < 9; i++) begin
			p = (i % 2) ? in_word_t'{16'hffff, 16'hffff, 16'hffff} :
				in_word_t'{CH_W'($urandom), CH_W'($urandom), CH_W'($urandom)};
			dir_tab.push_back('{i == 0, 3, p, 0, none});
		end

		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// first word straight after reset runs at the maximum size
		send_word('{16'h00ff, 16'hff00, 16'h5a5a}, 0, none);
		foreach (dir_tab[i]) begin
			if (dir_tab[i].cfg) begin
				in_valid <= 0;
				set_size(dir_tab[i].size);
			end
			send_word(dir_tab[i].px, dir_tab[i].typed, dir_tab[i].exp);
		end

		for (int ph = 0; ph < 6; ph++) begin
			in_valid <= 0;
			set_size(FS_W'(phase_size[ph]));
			quiet = (ph == 3);
			for (int i = 0; i < phase_len[ph]; i++) begin
				if (ph == 2 && i == 15) begin
					in_valid <= 0;
					wait (blur_q.size() == 0);
					@(posedge clk);
				end
				send_word('{rand_chan(), rand_chan(), rand_chan()}, 0, none);
			end
		end
		in_valid <= 0;
		quiet = 0;

		wait (blur_q.size() == 0);
		repeat (40) @(posedge clk);
		$display("%0d pixels in, %0d blurred words out, %0d frame size writes",
			words_in, words_out, size_writes);
		$display("sizes 0, 1, 2, 3, 4, 5, 7, 512 and oversize, with random stalls on both sides");
		if (errors == 0) begin
			$display("box_blur_3x3_clipped regression: pass");
		end else begin
			$display("box_blur_3x3_clipped regression: fail");
		end
		$finish;
	end
endmodule
